// ===== sv/kbpm_pkg.sv =====
package kbpm_pkg;

   localparam int KEY_W = 33;
   localparam int AGE_W = 32;

   localparam logic [2:0] ST_REUSED       = 3'd0;
   localparam logic [2:0] ST_NEW_BACKED   = 3'd1;
   localparam logic [2:0] ST_NEW_UNBACKED = 3'd2;
   localparam logic [2:0] ST_POOL_FULL    = 3'd3;
   localparam logic [2:0] ST_RELEASED     = 3'd4;
   localparam logic [2:0] ST_RELEASE_ERR  = 3'd5;

   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [13:0] req_width;
      logic [13:0] req_height;
      logic        req_is_rgb;
      logic [3:0]  req_format;
      logic        backing_ok;
      logic [3:0]  release_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [15:0] freed_mask;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_COMPARE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic compare;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic last_entry;
   } sts_type;

endpackage

// ===== sv/keyed_buffer_pool_manager.sv =====
// Channel   Ports                           Payload              Direction
// request   req_valid, req_stall, req_data  kbpm_pkg::req_type   in
// response  rsp_valid, rsp_stall, rsp_data  kbpm_pkg::rsp_type   out
//
// An acquire scans every entry before its response is loaded; the single read port of the key
// and age memories gives each entry a read step followed by a compare step. A release's response
// is loaded in the final step, after a single read step.
// Reset clears the in-use and allocated marks and the grant counter; no clearing pass is needed.
// One transaction is in flight at a time; a new request is taken while the previous response
// waits, and a stalled response holds the block in its final step.
module keyed_buffer_pool_manager #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  kbpm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kbpm_pkg::rsp_type  rsp_data
);

   kbpm_pkg::cmd_type cmd;
   kbpm_pkg::sts_type sts;

   kbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kbpm_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sv/kbpm_ctrl.sv =====
module kbpm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  kbpm_pkg::sts_type  sts,
   output kbpm_pkg::cmd_type  cmd
);

   kbpm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kbpm_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = kbpm_pkg::S_READ;
            end
         end
         kbpm_pkg::S_READ: begin
            if (sts.is_release) begin
               state_in = kbpm_pkg::S_FINISH;
            end else begin
               state_in = kbpm_pkg::S_COMPARE;
            end
         end
         kbpm_pkg::S_COMPARE: begin
            if (sts.last_entry) begin
               state_in = kbpm_pkg::S_FINISH;
            end else begin
               state_in = kbpm_pkg::S_READ;
            end
         end
         kbpm_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = kbpm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kbpm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         kbpm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         kbpm_pkg::S_READ: begin
            cmd.read = 1'b1;
         end
         kbpm_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
         end
         kbpm_pkg::S_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kbpm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/kbpm_datapath.sv =====
module kbpm_datapath #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  kbpm_pkg::req_type  req_data,
   input  kbpm_pkg::cmd_type  cmd,
   output kbpm_pkg::sts_type  sts,
   output kbpm_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   logic [kbpm_pkg::KEY_W-1:0] key_mem [NUM_ENTRIES];
   logic [kbpm_pkg::AGE_W-1:0] age_mem [NUM_ENTRIES];

   kbpm_pkg::req_type          req_ff;
   kbpm_pkg::rsp_type          rsp_ff;
   logic [NUM_ENTRIES-1:0]     in_use_ff;
   logic [NUM_ENTRIES-1:0]     alloc_ff;
   logic [kbpm_pkg::AGE_W-1:0] counter_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [kbpm_pkg::KEY_W-1:0] key_rd_ff;
   logic [kbpm_pkg::AGE_W-1:0] age_rd_ff;
   logic                       best_vld_ff;
   logic [IDX_W-1:0]           best_idx_ff;
   logic [kbpm_pkg::AGE_W-1:0] best_age_ff;
   logic                       first_vld_ff;
   logic [IDX_W-1:0]           first_idx_ff;
   logic [15:0]                freed_ff;

   logic [kbpm_pkg::KEY_W-1:0] req_key;
   logic                       cur_idle_alloc;
   logic                       cur_mismatch;
   logic                       rel_ok;
   logic [IDX_W-1:0]           rel_idx;
   logic                       grant_vld;
   logic                       grant_new;
   logic [IDX_W-1:0]           grant_idx;
   logic                       is_acquire;

   assign req_key = {req_ff.req_format, req_ff.req_is_rgb, req_ff.req_height,
                     req_ff.req_width};
   assign is_acquire = req_ff.func == kbpm_pkg::FUNC_ACQUIRE;
   assign cur_idle_alloc = !in_use_ff[idx_ff] && alloc_ff[idx_ff];
   assign cur_mismatch = cur_idle_alloc && (key_rd_ff != req_key);

   assign rel_idx = IDX_W'(req_ff.release_slot);
   assign rel_ok = ({4'd0, req_ff.release_slot} < 8'(NUM_ENTRIES)) && in_use_ff[rel_idx];

   assign grant_new = !best_vld_ff && first_vld_ff;
   assign grant_vld = best_vld_ff || first_vld_ff;
   assign grant_idx = best_vld_ff ? best_idx_ff : first_idx_ff;

   assign sts.is_release = req_ff.func == kbpm_pkg::FUNC_RELEASE;
   assign sts.last_entry = idx_ff == LAST_IDX;

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         key_rd_ff <= key_mem[idx_ff];
         age_rd_ff <= age_mem[idx_ff];
      end
      if (cmd.finish && is_acquire && grant_vld) begin
         age_mem[grant_idx] <= counter_ff;
         if (grant_new) begin
            key_mem[grant_idx] <= req_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.load) begin
         idx_ff <= '0;
         freed_ff <= '0;
      end else if (cmd.compare) begin
         if (!sts.last_entry) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cur_mismatch) begin
            freed_ff <= freed_ff | (16'd1 << idx_ff);
         end
         if (cur_idle_alloc && !cur_mismatch) begin
            if (!best_vld_ff || !(best_age_ff < age_rd_ff)) begin
               best_idx_ff <= idx_ff;
               best_age_ff <= age_rd_ff;
            end
         end
         if (!in_use_ff[idx_ff] && !first_vld_ff) begin
            first_idx_ff <= idx_ff;
         end
      end
      if (cmd.finish) begin
         if (is_acquire) begin
            rsp_ff.freed_mask <= freed_ff;
            if (best_vld_ff) begin
               rsp_ff.status <= kbpm_pkg::ST_REUSED;
               rsp_ff.slot <= 4'(best_idx_ff);
            end else if (first_vld_ff) begin
               rsp_ff.status <= req_ff.backing_ok ? kbpm_pkg::ST_NEW_BACKED
                                                  : kbpm_pkg::ST_NEW_UNBACKED;
               rsp_ff.slot <= 4'(first_idx_ff);
            end else begin
               rsp_ff.status <= kbpm_pkg::ST_POOL_FULL;
               rsp_ff.slot <= 4'd0;
            end
         end else begin
            rsp_ff.freed_mask <= 16'd0;
            rsp_ff.slot <= req_ff.release_slot;
            rsp_ff.status <= rel_ok ? kbpm_pkg::ST_RELEASED : kbpm_pkg::ST_RELEASE_ERR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         alloc_ff <= '0;
         counter_ff <= '0;
         best_vld_ff <= 1'b0;
         first_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            best_vld_ff <= 1'b0;
            first_vld_ff <= 1'b0;
         end else if (cmd.compare) begin
            if (cur_mismatch) begin
               alloc_ff[idx_ff] <= 1'b0;
            end
            if (cur_idle_alloc && !cur_mismatch) begin
               best_vld_ff <= 1'b1;
            end
            if (!in_use_ff[idx_ff]) begin
               first_vld_ff <= 1'b1;
            end
         end else if (cmd.finish) begin
            if (is_acquire) begin
               if (grant_vld) begin
                  in_use_ff[grant_idx] <= 1'b1;
                  counter_ff <= counter_ff + 32'd1;
                  if (grant_new) begin
                     alloc_ff[grant_idx] <= req_ff.backing_ok;
                  end
               end
            end else if (rel_ok) begin
               in_use_ff[rel_idx] <= 1'b0;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
